[hw/rtl/pvs_pkg.sv]
// Shared widths, codes and limits of the PID velocity step block.
package pvs_pkg;

    localparam int KIND_W = 2;
    localparam int VEL_W  = 32;
    localparam int GAIN_W = 24;
    localparam int SUM_W  = 40;
    localparam int IDX_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_STEP  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    localparam logic [IDX_W-1:0] REG_PROP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTEG = 2'd1;
    localparam logic [IDX_W-1:0] REG_DERIV = 2'd2;

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

[hw/rtl/pvs_in_if.sv]
// Input channel of the PID velocity step block: valid, ready and one input word.
interface pvs_in_if;
    import pvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [KIND_W-1:0] kind;
    logic signed [VEL_W-1:0]  setpoint;
    logic signed [VEL_W-1:0]  load_value;

    modport source (output valid, kind, setpoint, load_value, input ready);
    modport sink   (input valid, kind, setpoint, load_value, output ready);
endinterface

[hw/rtl/pvs_out_if.sv]
// Result channel of the PID velocity step block: valid, ready and one result word.
interface pvs_out_if;
    import pvs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity_out;
    logic                    saturated;

    modport source (output valid, velocity_out, saturated, input ready);
    modport sink   (input valid, velocity_out, saturated, output ready);
endinterface

[hw/rtl/pid_velocity_step_core.sv]
// PID velocity step core: fixed-point PID loop with a built-in velocity plant.
//
//   channel  dir  handshake         payload
//   i_in     in   valid / ready     kind, setpoint, load_value
//   o_out    out  valid / ready     velocity_out, saturated
//   i_cfg    in   i_cfg_we only     i_cfg_idx, i_cfg_data (gain registers)
//
// One word per cycle sustained while the result is taken; an accepted word waits in the input
// register and moves to the result register when that register advances. It feeds one pass of logic
// (error, integral, three gain multiplies, drive and velocity clamps) that updates the loop
// state and the result register at the same edge, so the velocity feedback closes within
// that single pass. A stalled result holds the result register; the input register
// then takes one more word and ready drops. Reset (synchronous, active low)
// clears the gains, velocity, integral and previous error.
module pid_velocity_step_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pvs_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [pvs_pkg::GAIN_W-1:0]  i_cfg_data,
    pvs_in_if.sink                      i_in,
    pvs_out_if.source                   o_out
);
    import pvs_pkg::*;

    // Widths of the exact products and of the drive sum.
    localparam int PP_W  = GAIN_W + VEL_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int PD_W  = GAIN_W + VEL_W + 1;
    localparam int DRV_W = PI_W + 2;

    // Gain registers
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd;

    // Loop state
    logic signed [VEL_W-1:0]  r_vel, n_vel;
    logic signed [SUM_W-1:0]  r_err_sum, n_err_sum;
    logic signed [VEL_W-1:0]  r_last_err, n_last_err;

    // Input register
    logic                     r_in_valid;
    logic        [KIND_W-1:0] r_in_kind;
    logic signed [VEL_W-1:0]  r_in_sp;
    logic signed [VEL_W-1:0]  r_in_load;

    // Result register
    logic                     r_out_valid;
    logic signed [VEL_W-1:0]  r_out_vel;
    logic                     r_out_sat;
    logic                     n_out_sat;

    logic advance;
    logic process;

    // Step datapath
    logic signed [VEL_W:0]    err_wide;
    logic signed [VEL_W-1:0]  err;
    logic                     sat_err;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_new;
    logic                     sat_sum;
    logic signed [VEL_W:0]    diff;
    logic signed [PP_W-1:0]   p_prop;
    logic signed [PI_W-1:0]   p_int;
    logic signed [PD_W-1:0]   p_der;
    logic signed [DRV_W-1:0]  sh_prop, sh_int, sh_der, drv_sum;
    logic [DRV_W-VEL_W:0]     drv_hi;
    logic signed [VEL_W-1:0]  drive;
    logic                     sat_drv;
    logic signed [VEL_W:0]    vel_wide;
    logic signed [VEL_W-1:0]  vel_new;
    logic                     sat_vel;

    // Advance the result register when it is empty or being taken.
    assign advance     = !r_out_valid || o_out.ready;
    assign process     = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;

    assign o_out.valid        = r_out_valid;
    assign o_out.velocity_out = r_out_vel;
    assign o_out.saturated    = r_out_sat;

    // Error, clamped to the velocity range.
    always_comb begin
        err_wide = {r_in_sp[VEL_W-1], r_in_sp} - {r_vel[VEL_W-1], r_vel};
        sat_err  = err_wide[VEL_W] != err_wide[VEL_W-1];
        if (sat_err) begin
            err = err_wide[VEL_W] ? VEL_MIN : VEL_MAX;
        end else begin
            err = err_wide[VEL_W-1:0];
        end
    end

    // Integral, clamped to its 40-bit range.
    always_comb begin
        sum_wide = {r_err_sum[SUM_W-1], r_err_sum}
                 + {{(SUM_W-VEL_W+1){err[VEL_W-1]}}, err};
        sat_sum  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
        if (sat_sum) begin
            sum_new = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_new = sum_wide[SUM_W-1:0];
        end
    end

    // Exact products, each floored by the fraction shift.
    assign diff    = {err[VEL_W-1], err} - {r_last_err[VEL_W-1], r_last_err};
    assign p_prop  = r_kp * err;
    assign p_int   = r_ki * sum_new;
    assign p_der   = r_kd * diff;
    assign sh_prop = DRV_W'(p_prop >>> FRAC_BITS);
    assign sh_int  = DRV_W'(p_int >>> FRAC_BITS);
    assign sh_der  = DRV_W'(p_der >>> FRAC_BITS);
    assign drv_sum = sh_prop + sh_int + sh_der;

    // Drive clamp: in range only when the sign bit and all bits above it agree.
    always_comb begin
        drv_hi  = drv_sum[DRV_W-1:VEL_W-1];
        sat_drv = !((&drv_hi) || !(|drv_hi));
        if (sat_drv) begin
            drive = drv_sum[DRV_W-1] ? VEL_MIN : VEL_MAX;
        end else begin
            drive = drv_sum[VEL_W-1:0];
        end
    end

    // New velocity, clamped.
    always_comb begin
        vel_wide = {r_vel[VEL_W-1], r_vel} + {drive[VEL_W-1], drive};
        sat_vel  = vel_wide[VEL_W] != vel_wide[VEL_W-1];
        if (sat_vel) begin
            vel_new = vel_wide[VEL_W] ? VEL_MIN : VEL_MAX;
        end else begin
            vel_new = vel_wide[VEL_W-1:0];
        end
    end

    // Select the state update by word kind; the unused kind changes nothing.
    always_comb begin
        n_vel      = r_vel;
        n_err_sum  = r_err_sum;
        n_last_err = r_last_err;
        n_out_sat  = 1'b0;
        case (t_kind'(r_in_kind))
            KIND_STEP: begin
                n_vel      = vel_new;
                n_err_sum  = sum_new;
                n_last_err = err;
                n_out_sat  = sat_err | sat_sum | sat_drv | sat_vel;
            end
            KIND_LOAD: begin
                n_vel = r_in_load;
            end
            KIND_CLEAR: begin
                n_err_sum  = '0;
                n_last_err = '0;
            end
            default: begin
            end
        endcase
    end

    // Gain writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP:  r_kp <= i_cfg_data;
                REG_INTEG: r_ki <= i_cfg_data;
                REG_DERIV: r_kd <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: load on accept, drain when processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_sp   <= i_in.setpoint;
            r_in_load <= i_in.load_value;
        end
    end

    // Loop state advances together with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel       <= '0;
            r_err_sum   <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_vel      <= n_vel;
                r_err_sum  <= n_err_sum;
                r_last_err <= n_last_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_vel <= n_vel;
            r_out_sat <= n_out_sat;
        end
    end

    // The result carries the state that the same edge stored.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> (r_out_vel == r_vel))
        else $error("result velocity differs from stored velocity");

    a_load_sets_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_kind == KIND_LOAD) |=> (r_vel == $past(r_in_load)))
        else $error("load word did not set velocity");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_kind == KIND_CLEAR) |=> (r_err_sum == '0 && r_last_err == '0))
        else $error("clear word left integral or previous error");

    a_sat_only_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_kind != KIND_STEP) |=> !r_out_sat)
        else $error("saturation flag on a non-step word");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled with room in the pipeline");

endmodule
